FILE: rtl/pfa_pkg.sv
`default_nettype none
package pfa_pkg;
  localparam int PAGE_BYTES = 1024;
  localparam int FRAME_COUNT = 32;
  localparam int PROCESS_SLOTS = 8;
  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int SLOT_W = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int PAGES_W = $clog2(FRAME_COUNT + 1);
  localparam int PMAP_W = SLOT_W + FRAME_W;
  localparam int PHYS_W = FRAME_W + OFF_W;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ABSENT = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_DUP = 3'd4;
  localparam logic [2:0] ST_NO_SLOT = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_MAP, S_MEM, S_WALK, S_DONE
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/paged_frame_allocator_mmu.sv
`default_nettype none
// One operation is taken at a time and answered by one result beat. A read or
// write that fails its checks goes from acceptance through a slot lookup, then
// the checks, to the result register. A write that passes also makes the
// physical memory access before its result is registered. A read that passes
// first reads the page table and then the memory, each a registered read,
// before its result is registered. Create walks the frame table one frame per
// cycle until it has taken all its frames, then a closing step records the
// slot; free walks its pages one per cycle, then a closing step. A new
// operation is accepted only once the result register is empty or being read
// in the same cycle.
module paged_frame_allocator_mmu
  import pfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] pid,
  input  wire logic [15:0] logical_address,
  input  wire logic [15:0] process_size,
  input  wire logic [15:0] code_length,
  input  wire logic [7:0]  write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [7:0]       read_data,
  output logic [5:0]       free_frames
);
  state_t state, state_next;
  logic [1:0] op;
  logic [15:0] r_pid, r_addr, r_clen;
  logic [16:0] r_size;
  logic [7:0] r_wdata;

  logic [PROCESS_SLOTS-1:0] slot_valid;
  logic [15:0] slot_pid [PROCESS_SLOTS];
  logic [PAGES_W-1:0] slot_pages [PROCESS_SLOTS];
  logic [15:0] slot_clen [PROCESS_SLOTS];

  // Frame ownership: one free bit per frame.
  logic [FRAME_COUNT-1:0] frame_free;
  logic [PAGES_W-1:0] nfree;

  logic [SLOT_W-1:0] slot;
  logic hit, have_free;
  logic [SLOT_W-1:0] fslot;
  logic [PAGES_W-1:0] pages;
  logic [PAGES_W:0] walk;
  logic [PAGES_W-1:0] j;

  logic look_hit, look_free;
  logic [SLOT_W-1:0] look_slot, look_fslot;
  logic [2:0] chk_status;
  logic chk_go;
  logic create_end, free_end;

  logic pm_we;
  logic [PMAP_W-1:0] pm_waddr, pm_raddr;
  logic [FRAME_W-1:0] pm_wdata, pm_rdata;
  logic mem_we;
  logic [PHYS_W-1:0] mem_addr;
  logic [7:0] mem_rdata;
  logic mem_rd;

  pfa_ram #(.WIDTH(FRAME_W), .ADDR_W(PMAP_W)) u_pmap (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata));
  pfa_ram #(.WIDTH(8), .ADDR_W(PHYS_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_addr), .wdata(r_wdata),
    .raddr(mem_addr), .rdata(mem_rdata));

  logic [15:0] page_num;
  assign page_num = r_addr >> OFF_W;
  logic [16:0] size_up;
  assign size_up = r_size + 17'(PAGE_BYTES - 1);
  logic [FRAME_W-1:0] wf;
  assign wf = walk[FRAME_W-1:0];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  assign create_end = (j >= pages) || (walk >= (PAGES_W+1)'(FRAME_COUNT));
  assign free_end = (walk >= (PAGES_W+1)'(slot_pages[slot])) ||
                    (walk >= (PAGES_W+1)'(FRAME_COUNT));

  // Slot search: the lowest matching slot and the lowest empty slot win.
  always_comb begin
    look_hit = 1'b0;
    look_slot = '0;
    look_free = 1'b0;
    look_fslot = '0;
    for (int s = PROCESS_SLOTS - 1; s >= 0; s--) begin
      if (slot_valid[s] && slot_pid[s] == r_pid) begin
        look_hit = 1'b1;
        look_slot = SLOT_W'(s);
      end
      if (!slot_valid[s]) begin
        look_free = 1'b1;
        look_fslot = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    chk_status = ST_OK;
    chk_go = 1'b0;
    case (op)
      OP_CREATE: begin
        if (hit) chk_status = ST_DUP;
        else if (!have_free) chk_status = ST_NO_SLOT;
        else if ((size_up >> OFF_W) > 17'(nfree)) chk_status = ST_TOO_LARGE;
        else chk_go = 1'b1;
      end
      OP_FREE: begin
        if (!hit) chk_status = ST_ABSENT;
        else chk_go = 1'b1;
      end
      OP_READ: begin
        if (!hit) chk_status = ST_ABSENT;
        else if (page_num >= 16'(slot_pages[slot])) chk_status = ST_ILLEGAL;
        else chk_go = 1'b1;
      end
      default: begin
        if (!hit) chk_status = ST_ABSENT;
        else if (r_addr < slot_clen[slot] ||
                 {6'd0, page_num} >= 22'(slot_pages[slot]))
          chk_status = ST_ILLEGAL;
        else chk_go = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && in_ready) state_next = S_LOOK;
      S_LOOK: state_next = S_MAP;
      S_MAP: begin
        if (!chk_go) state_next = S_DONE;
        else if (op == OP_CREATE || op == OP_FREE) state_next = S_WALK;
        else state_next = S_MEM;
      end
      S_MEM: begin
        if (op == OP_READ) state_next = S_WALK;
        else state_next = S_DONE;
      end
      S_WALK: begin
        if (op == OP_READ) state_next = S_DONE;
        else if (op == OP_CREATE) begin
          if (create_end) state_next = S_DONE;
        end else if (free_end && (!mem_rd || walk != '0)) state_next = S_DONE;
      end
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pm_raddr = {slot, page_num[FRAME_W-1:0]};
    if (state == S_WALK && op == OP_FREE) pm_raddr = {slot, walk[FRAME_W-1:0]};
    pm_we = (state == S_WALK) && (op == OP_CREATE) && (j < pages) &&
            !walk[PAGES_W] && (walk < (PAGES_W+1)'(FRAME_COUNT)) && frame_free[wf];
    pm_waddr = {fslot, j[FRAME_W-1:0]};
    pm_wdata = wf;
    mem_addr = {pm_rdata, r_addr[OFF_W-1:0]};
    mem_we = (state == S_MEM) && (op == OP_WRITE) && mem_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot_valid <= '0;
      frame_free <= '1;
      nfree <= PAGES_W'(FRAME_COUNT);
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        free_frames <= 6'(nfree);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= opcode; r_pid <= pid; r_addr <= logical_address;
            r_size <= {1'b0, process_size}; r_clen <= code_length;
            r_wdata <= write_data;
          end
        end
        S_LOOK: begin
          hit <= look_hit; slot <= look_slot;
          have_free <= look_free; fslot <= look_fslot;
          pages <= PAGES_W'(size_up >> OFF_W);
        end
        S_MAP: begin
          // Page table read for the looked-up slot is issued this cycle.
          status <= chk_status;
          read_data <= (op == OP_READ) ? 8'hFF : 8'h00;
          walk <= '0; j <= '0;
          mem_rd <= chk_go && (op == OP_READ || op == OP_WRITE);
        end
        S_WALK: begin
          if (op == OP_READ) begin
            read_data <= mem_rdata;
          end else if (op == OP_CREATE) begin
            if (create_end) begin
              slot_valid[fslot] <= 1'b1;
              slot_pid[fslot] <= r_pid;
              slot_pages[fslot] <= pages;
              slot_clen[fslot] <= r_clen;
            end else begin
              if (frame_free[wf]) begin
                frame_free[wf] <= 1'b0;
                nfree <= nfree - 1'b1;
                j <= j + 1'b1;
              end
              walk <= walk + 1'b1;
            end
          end else begin
            // Free: read page walk this cycle, release its frame the next.
            if (mem_rd) begin
              frame_free[pm_rdata] <= 1'b1;
              if (!frame_free[pm_rdata]) nfree <= nfree + 1'b1;
            end
            if (free_end) begin
              mem_rd <= 1'b0;
              if (!mem_rd || walk != '0) slot_valid[slot] <= 1'b0;
            end else begin
              mem_rd <= 1'b1;
              walk <= walk + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pfa_ram.sv
`default_nettype none
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [2**ADDR_W];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
